// File: design/npps_pkg.sv
// ----------------------------------------------------------------------------
// npps_pkg: shared types for the non-preemptive priority scheduler
// Request and result payloads, queue entry, job record and back-end states.
// ----------------------------------------------------------------------------
package npps_pkg;

  localparam logic [23:0] CLK_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [15:0] job_number;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
    logic [7:0]  job_priority;
    logic        last_job;
  } job_in_t;

  typedef struct packed {
    logic [5:0]  slot_index;
    logic [15:0] job_id_out;
    logic [7:0]  priority_out;
    logic [23:0] start_time;
    logic [23:0] completion_time;
    logic [23:0] waiting_time;
    logic [23:0] turnaround_time;
    logic        idle_before;
    logic [31:0] total_waiting;
    logic [31:0] total_turnaround;
    logic        last_result;
  } job_out_t;

  // classified request handed from front to back
  typedef struct packed {
    job_in_t job;
    logic    store;
  } npps_cmd_t;

  // one stored job
  typedef struct packed {
    logic [15:0] number;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
  } npps_rec_t;

  typedef enum logic [2:0] {
    BK_LOAD,
    BK_SCAN,
    BK_PICK,
    BK_CALC1,
    BK_CALC2,
    BK_EMIT
  } bk_state_t;

endpackage

// File: design/npps_front.sv
// ----------------------------------------------------------------------------
// npps_front: request intake
// Accepts requests, tracks the batch fill and tags each one as stored or dropped.
// ----------------------------------------------------------------------------
module npps_front #(
  parameter int MAX_JOBS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  npps_pkg::job_in_t   in_data,
  input  logic                q_full,
  output logic                push,
  output npps_pkg::npps_cmd_t push_data
);

  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             room;

  assign push = start && !q_full;
  assign room = (cnt_r < CNT_W'(MAX_JOBS));

  always_comb begin
    push_data.job   = in_data;
    push_data.store = room;
    cnt_nxt         = cnt_r;
    if (push) begin
      if (in_data.last_job) begin
        cnt_nxt = '0;
      end else if (room) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: design/npps_queue.sv
// ----------------------------------------------------------------------------
// npps_queue: two-entry request queue
// Decouples intake from the scheduler so each side stalls on its own.
// ----------------------------------------------------------------------------
module npps_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  npps_pkg::npps_cmd_t push_data,
  input  logic                pop,
  output npps_pkg::npps_cmd_t pop_data,
  output logic                full,
  output logic                empty
);

  npps_pkg::npps_cmd_t ent_r [2];
  logic                wr_ptr_r, wr_ptr_nxt;
  logic                rd_ptr_r, rd_ptr_nxt;
  logic [1:0]          cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/npps_back.sv
// ----------------------------------------------------------------------------
// npps_back: job store and scheduler
// Stores tagged jobs, then per decision scans the store one entry a cycle.
// ----------------------------------------------------------------------------
module npps_back #(
  parameter int MAX_JOBS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  npps_pkg::npps_cmd_t q_data,
  output logic                pop,
  output logic                out_valid,
  output npps_pkg::job_out_t  out_data
);

  localparam int SLOT_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W  = $clog2(MAX_JOBS + 1);

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFFFFFF : s[31:0];
  endfunction

  npps_pkg::npps_rec_t mem [MAX_JOBS];
  npps_pkg::npps_rec_t rd_data_r;
  npps_pkg::npps_rec_t best_r, best_nxt;
  npps_pkg::npps_rec_t wr_rec;
  npps_pkg::job_out_t  out_r, out_nxt;
  npps_pkg::bk_state_t state_r, state_nxt;

  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic [CNT_W-1:0]    issue_r, issue_nxt;
  logic [SLOT_W-1:0]   rd_slot_r, rd_slot_nxt;
  logic [SLOT_W-1:0]   best_slot_r, best_slot_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                found_r, found_nxt;
  logic                idle_r, idle_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MAX_JOBS-1:0] done_r, done_nxt;
  logic [15:0]         min_arr_r, min_arr_nxt;
  logic [23:0]         clock_r, clock_nxt;
  logic [23:0]         finish_r, finish_nxt;
  logic [23:0]         wait_r, wait_nxt;
  logic [23:0]         tat_r, tat_nxt;
  logic [31:0]         sum_w_r, sum_w_nxt;
  logic [31:0]         sum_t_r, sum_t_nxt;
  logic                wr_en, rd_en;
  logic [SLOT_W-1:0]   rd_addr;
  logic                cand_done, cand_ready, cand_better;
  logic [24:0]         fin_sum;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign wr_rec.number  = q_data.job.job_number;
  assign wr_rec.arrival = q_data.job.arrival_time;
  assign wr_rec.burst   = q_data.job.burst_time;
  assign wr_rec.prio    = q_data.job.job_priority;

  // candidate from the registered read
  assign cand_done   = done_r[rd_slot_r];
  assign cand_ready  = !cand_done && ({8'h00, rd_data_r.arrival} <= clock_r);
  assign cand_better = !found_r || (rd_data_r.prio > best_r.prio) ||
                       ((rd_data_r.prio == best_r.prio) &&
                        (rd_data_r.number < best_r.number));
  assign fin_sum     = {1'b0, clock_r} + {9'h000, best_r.burst};

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    issue_nxt     = issue_r;
    rd_slot_nxt   = rd_slot_r;
    rd_vld_nxt    = 1'b0;
    best_nxt      = best_r;
    best_slot_nxt = best_slot_r;
    found_nxt     = found_r;
    idle_nxt      = idle_r;
    done_nxt      = done_r;
    min_arr_nxt   = min_arr_r;
    clock_nxt     = clock_r;
    finish_nxt    = finish_r;
    wait_nxt      = wait_r;
    tat_nxt       = tat_r;
    sum_w_nxt     = sum_w_r;
    sum_t_nxt     = sum_t_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    pop           = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = issue_r[SLOT_W-1:0];

    unique case (state_r)
      npps_pkg::BK_LOAD: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (q_data.store) begin
            wr_en = 1'b1;
            n_nxt = n_r + 1'b1;
          end
          if (q_data.job.last_job) begin
            clock_nxt = '0;
            sum_w_nxt = '0;
            sum_t_nxt = '0;
            k_nxt     = '0;
            idle_nxt  = 1'b0;
            done_nxt  = '0;
            if (n_nxt != '0) begin
              state_nxt   = npps_pkg::BK_SCAN;
              issue_nxt   = '0;
              found_nxt   = 1'b0;
              min_arr_nxt = 16'hFFFF;
            end
          end
        end
      end

      npps_pkg::BK_SCAN: begin
        if (issue_r < n_r) begin
          rd_en       = 1'b1;
          rd_vld_nxt  = 1'b1;
          rd_slot_nxt = issue_r[SLOT_W-1:0];
          issue_nxt   = issue_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (cand_ready && cand_better) begin
            best_nxt      = rd_data_r;
            best_slot_nxt = rd_slot_r;
            found_nxt     = 1'b1;
          end
          if (!cand_done && (rd_data_r.arrival < min_arr_r)) begin
            min_arr_nxt = rd_data_r.arrival;
          end
          if (CNT_W'(rd_slot_r) == n_r - 1'b1) begin
            state_nxt = npps_pkg::BK_PICK;
          end
        end
      end

      npps_pkg::BK_PICK: begin
        priority if (found_r) begin
          state_nxt = npps_pkg::BK_CALC1;
        end else if (!idle_r) begin
          // nothing ready: jump to the next arrival and rescan
          clock_nxt   = {8'h00, min_arr_r};
          idle_nxt    = 1'b1;
          state_nxt   = npps_pkg::BK_SCAN;
          issue_nxt   = '0;
          min_arr_nxt = 16'hFFFF;
        end else begin
          state_nxt = npps_pkg::BK_LOAD;
          n_nxt     = '0;
          done_nxt  = '0;
          clock_nxt = '0;
          sum_w_nxt = '0;
          sum_t_nxt = '0;
        end
      end

      npps_pkg::BK_CALC1: begin
        finish_nxt = fin_sum[24] ? npps_pkg::CLK_MAX : fin_sum[23:0];
        wait_nxt   = clock_r - {8'h00, best_r.arrival};
        state_nxt  = npps_pkg::BK_CALC2;
      end

      npps_pkg::BK_CALC2: begin
        tat_nxt   = finish_r - {8'h00, best_r.arrival};
        sum_w_nxt = sat_add32(sum_w_r, {8'h00, wait_r});
        state_nxt = npps_pkg::BK_EMIT;
      end

      npps_pkg::BK_EMIT: begin
        sum_t_nxt                = sat_add32(sum_t_r, {8'h00, tat_r});
        out_valid_nxt            = 1'b1;
        out_nxt.slot_index       = 6'(best_slot_r);
        out_nxt.job_id_out       = best_r.number;
        out_nxt.priority_out     = best_r.prio;
        out_nxt.start_time       = clock_r;
        out_nxt.completion_time  = finish_r;
        out_nxt.waiting_time     = wait_r;
        out_nxt.turnaround_time  = tat_r;
        out_nxt.idle_before      = idle_r;
        out_nxt.total_waiting    = sum_w_r;
        out_nxt.total_turnaround = sum_t_nxt;
        out_nxt.last_result      = (k_r + 1'b1 == n_r);
        done_nxt[best_slot_r]    = 1'b1;
        clock_nxt                = finish_r;
        idle_nxt                 = 1'b0;
        k_nxt                    = k_r + 1'b1;
        if (k_r + 1'b1 == n_r) begin
          state_nxt = npps_pkg::BK_LOAD;
          n_nxt     = '0;
          done_nxt  = '0;
          clock_nxt = '0;
          sum_w_nxt = '0;
          sum_t_nxt = '0;
        end else begin
          state_nxt   = npps_pkg::BK_SCAN;
          issue_nxt   = '0;
          found_nxt   = 1'b0;
          min_arr_nxt = 16'hFFFF;
        end
      end

      default: state_nxt = npps_pkg::BK_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= npps_pkg::BK_LOAD;
      n_r         <= '0;
      k_r         <= '0;
      issue_r     <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      idle_r      <= 1'b0;
      done_r      <= '0;
      clock_r     <= '0;
      sum_w_r     <= '0;
      sum_t_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      issue_r     <= issue_nxt;
      rd_vld_r    <= rd_vld_nxt;
      found_r     <= found_nxt;
      idle_r      <= idle_nxt;
      done_r      <= done_nxt;
      clock_r     <= clock_nxt;
      sum_w_r     <= sum_w_nxt;
      sum_t_r     <= sum_t_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_slot_r   <= rd_slot_nxt;
    best_r      <= best_nxt;
    best_slot_r <= best_slot_nxt;
    min_arr_r   <= min_arr_nxt;
    finish_r    <= finish_nxt;
    wait_r      <= wait_nxt;
    tat_r       <= tat_nxt;
    out_r       <= out_nxt;
  end

  // job store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[n_r[SLOT_W-1:0]] <= wr_rec;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == npps_pkg::BK_EMIT))
    else $error("result strobe without an emit cycle");

  a_calc_has_pick: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == npps_pkg::BK_CALC1 |-> found_r)
    else $error("completion math started without a selected job");

  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> state_r == npps_pkg::BK_SCAN)
    else $error("store read returned outside a scan");

  a_jump_finds_job: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == npps_pkg::BK_PICK && idle_r) |-> found_r)
    else $error("no ready job after jumping to next arrival");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(MAX_JOBS))
    else $error("job store overfilled");

endmodule

// File: design/nonpreemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler: batch non-preemptive priority scheduler
// Loads jobs, then on the last one emits the run order with timing figures.
// ----------------------------------------------------------------------------
//
//  channel  ports                    handshake
//  -------  -----------------------  ------------------------------------
//  request  start, busy, in_data     taken when start && !busy
//  result   out_valid, out_data      one-cycle strobe, cannot be stalled
//
// A request is taken every cycle while loading; the store write
//   in the back end pops one queued request per cycle.
// A batch of n jobs is scheduled after its last request: each decision scans
//   the job store through its single registered read port, a second time
//   when the processor idles, then does the time math in CALC1, CALC2 and
//   EMIT, which raises the result strobe.
// busy rises only when the two-entry request queue is full, i.e. up to two
//   requests of the next batch are taken while a schedule is running.
// Reset is synchronous, active low; it empties the queue and the batch.
//   The job store itself is not cleared; only loaded entries are read.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler #(
  parameter int MAX_JOBS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  npps_pkg::job_in_t  in_data,
  output logic               out_valid,
  output npps_pkg::job_out_t out_data
);

  npps_pkg::npps_cmd_t push_data;
  npps_pkg::npps_cmd_t pop_data;
  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_empty;

  // request is held off only by a full queue
  assign busy = q_full;

  // intake: count the batch fill, tag stored vs dropped
  npps_front #(
    .MAX_JOBS (MAX_JOBS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // decoupling queue
  npps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // store and scheduler; pops only while loading
  npps_back #(
    .MAX_JOBS (MAX_JOBS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: dv/nonpreemptive_priority_scheduler_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_test: self-checking bench for the scheduler
// Loads job batches through the start/busy port and predicts the run order
// and timing figures of each batch. Every result strobe is checked field by
// field against the oldest predicted run.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler_test;

  localparam int MAX_JOBS        = 16;
  localparam int RANDOM_REQUESTS = 135;
  // room for the slowest batch to finish after its last request
  localparam int DRAIN_CYCLES    = MAX_JOBS * (2 * MAX_JOBS + 7) + 20;
  // ~170 requests and their schedules, allowed for many times over
  localparam int CYCLE_LIMIT     = 400_000;
  localparam int REPORT_CAP      = 40;

  // how the fields of a random job are drawn
  typedef enum int {
    MIX_FULL,     // every field over its whole range
    MIX_CROWDED,  // early arrivals, few priorities and numbers: lots of ties
    MIX_SPREAD    // far-apart arrivals with short bursts: lots of idling
  } job_mix_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the loaded batch, works out the run
  // order when the last request of a batch is noted, and checks results.
  // --------------------------------------------------------------------------
  class sched_scoreboard_t;
    npps_pkg::job_in_t  jobs[MAX_JOBS];
    int                 loaded;
    bit                 run_done[MAX_JOBS];
    logic [23:0]        run_clock;
    npps_pkg::job_out_t pending_runs[$];

    int unsigned mismatches;
    int unsigned requests;
    int unsigned dropped;
    int unsigned batches;
    int unsigned results_checked;
    int unsigned idle_starts;

    function new();
      loaded = 0;
      mismatches = 0;
      requests = 0;
      dropped = 0;
      batches = 0;
      results_checked = 0;
      idle_starts = 0;
    endfunction

    // best ready job: highest priority, then smaller number, then lower slot
    function int pick_ready();
      int best;
      best = -1;
      for (int i = 0; i < loaded; i++) begin
        if (run_done[i] || jobs[i].arrival_time > run_clock) continue;
        if (best < 0 || jobs[i].job_priority > jobs[best].job_priority ||
            (jobs[i].job_priority == jobs[best].job_priority &&
             jobs[i].job_number < jobs[best].job_number))
          best = i;
      end
      return best;
    endfunction

    function logic [23:0] earliest_arrival();
      logic [23:0] t;
      t = '1;
      for (int i = 0; i < loaded; i++)
        if (!run_done[i] && 24'(jobs[i].arrival_time) < t) t = 24'(jobs[i].arrival_time);
      return t;
    endfunction

    function void schedule_batch();
      logic [24:0]        finish_wide;
      logic [32:0]        acc;
      logic [23:0]        t_start, t_finish, t_wait, t_turn;
      logic [31:0]        sum_wait, sum_turn;
      npps_pkg::job_out_t r;
      int                 sel;
      bit                 idle;
      run_clock = '0;
      sum_wait  = '0;
      sum_turn  = '0;
      foreach (run_done[i]) run_done[i] = 1'b0;
      for (int k = 0; k < loaded; k++) begin
        idle = 1'b0;
        sel  = pick_ready();
        if (sel < 0) begin
          // nothing has arrived: jump ahead to the next arrival
          run_clock = earliest_arrival();
          idle      = 1'b1;
          sel       = pick_ready();
          if (sel < 0) break;
        end
        t_start     = run_clock;
        finish_wide = {1'b0, t_start} + 25'(jobs[sel].burst_time);
        t_finish    = finish_wide[24] ? npps_pkg::CLK_MAX : finish_wide[23:0];
        run_clock   = t_finish;
        t_wait      = t_start - 24'(jobs[sel].arrival_time);
        t_turn      = t_finish - 24'(jobs[sel].arrival_time);
        acc         = {1'b0, sum_wait} + 33'(t_wait);
        sum_wait    = acc[32] ? '1 : acc[31:0];
        acc         = {1'b0, sum_turn} + 33'(t_turn);
        sum_turn    = acc[32] ? '1 : acc[31:0];
        run_done[sel] = 1'b1;

        r.slot_index       = 6'(sel);
        r.job_id_out       = jobs[sel].job_number;
        r.priority_out     = jobs[sel].job_priority;
        r.start_time       = t_start;
        r.completion_time  = t_finish;
        r.waiting_time     = t_wait;
        r.turnaround_time  = t_turn;
        r.idle_before      = idle;
        r.total_waiting    = sum_wait;
        r.total_turnaround = sum_turn;
        r.last_result      = (k == loaded - 1);
        pending_runs.push_back(r);
      end
      batches++;
    endfunction

    // an accepted request: store it if there is room, schedule on last_job
    function void note_request(npps_pkg::job_in_t req);
      requests++;
      if (loaded < MAX_JOBS) begin
        jobs[loaded] = req;
        loaded++;
      end else begin
        dropped++;
      end
      if (req.last_job) begin
        schedule_batch();
        loaded = 0;
      end
    endfunction

    task report(string what);
      if (mismatches < REPORT_CAP) $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0h, expected %0h",
                         results_checked, name, got, want));
    endtask

    task check_result(npps_pkg::job_out_t got);
      npps_pkg::job_out_t want;
      if (pending_runs.size() == 0) begin
        report($sformatf("result with nothing pending: job %0h slot %0d",
                         got.job_id_out, got.slot_index));
        return;
      end
      want = pending_runs.pop_front();
      results_checked++;
      if (want.idle_before) idle_starts++;
      compare_field("slot_index",       got.slot_index,       want.slot_index);
      compare_field("job_id_out",       got.job_id_out,       want.job_id_out);
      compare_field("priority_out",     got.priority_out,     want.priority_out);
      compare_field("start_time",       got.start_time,       want.start_time);
      compare_field("completion_time",  got.completion_time,  want.completion_time);
      compare_field("waiting_time",     got.waiting_time,     want.waiting_time);
      compare_field("turnaround_time",  got.turnaround_time,  want.turnaround_time);
      compare_field("idle_before",      got.idle_before,      want.idle_before);
      compare_field("total_waiting",    got.total_waiting,    want.total_waiting);
      compare_field("total_turnaround", got.total_turnaround, want.total_turnaround);
      compare_field("last_result",      got.last_result,      want.last_result);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  npps_pkg::job_in_t  in_data;
  logic               out_valid;
  npps_pkg::job_out_t out_data;

  sched_scoreboard_t sched_sb;
  int burst_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nonpreemptive_priority_scheduler #(
    .MAX_JOBS(MAX_JOBS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic npps_pkg::job_in_t make_job(logic [15:0] num, logic [15:0] arr,
                                                 logic [15:0] burst, logic [7:0] prio,
                                                 logic last);
    npps_pkg::job_in_t j;
    j.job_number   = num;
    j.arrival_time = arr;
    j.burst_time   = burst;
    j.job_priority = prio;
    j.last_job     = last;
    return j;
  endfunction

  function automatic npps_pkg::job_in_t random_job(job_mix_t mix, logic last);
    npps_pkg::job_in_t j;
    unique case (mix)
      MIX_FULL: begin
        j.job_number   = 16'($urandom_range(0, 16'hFFFF));
        j.arrival_time = 16'($urandom_range(0, 16'hFFFF));
        j.burst_time   = 16'($urandom_range(0, 16'hFFFF));
        j.job_priority = 8'($urandom_range(0, 8'hFF));
      end
      MIX_CROWDED: begin
        j.job_number   = 16'($urandom_range(0, 7));
        j.arrival_time = 16'($urandom_range(0, 40));
        j.burst_time   = 16'($urandom_range(0, 15));
        j.job_priority = 8'($urandom_range(0, 3));
      end
      default: begin
        j.job_number   = 16'($urandom_range(0, 16'hFFFF));
        j.arrival_time = 16'($urandom_range(0, 16'hFFFF));
        j.burst_time   = 16'($urandom_range(0, 400));
        j.job_priority = 8'($urandom_range(0, 8'hFF));
      end
    endcase
    j.last_job = last;
    return j;
  endfunction

  // Sender pacing: bursts of random length, random gaps in between, and now
  // and then a long burst with no gap at all. During a gap start is low and
  // in_data carries junk (last_job included) that the block must ignore.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      start   <= 1'b0;
      in_data <= random_job(MIX_FULL, 1'($urandom_range(0, 1)));
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                              : $urandom_range(0, 10);
    end
  endtask

  // Present one request and hold it until the block takes it. start stays
  // high across back-to-back requests; only pace() lowers it.
  task automatic send_request(npps_pkg::job_in_t req);
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    sched_sb.note_request(req);
    pace();
  endtask

  // --------------------------------------------------------------------------
  // Result monitor: a strobe lasts one cycle and is taken at the edge that
  // ends it, so every high out_valid seen at an edge is one result.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) sched_sb.check_result(out_data);
  end

  // Watchdog: a hang or a lost result ends the run here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int       random_sent;
    int       batch_size;
    job_mix_t batch_mix;
    job_mix_t item_mix;

    sched_sb   = new();
    burst_left = 0;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // -- directed part --
    // one-job batch, every field at its top value: the processor idles first
    send_request(make_job(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1));

    // all arrive at tick 0; one zero burst; equal priorities fall back to the
    // smaller number, then to the earlier slot for a repeated number
    send_request(make_job(16'd5, 16'd0, 16'd0,  8'd0,   1'b0));
    send_request(make_job(16'd3, 16'd0, 16'd10, 8'd0,   1'b0));
    send_request(make_job(16'd3, 16'd0, 16'd7,  8'd0,   1'b0));
    send_request(make_job(16'd9, 16'd0, 16'd1,  8'hFF,  1'b1));

    // nothing ready at tick 0, and two more idle stretches later on
    send_request(make_job(16'd1, 16'd100, 16'd5,  8'd1,   1'b0));
    send_request(make_job(16'd2, 16'd50,  16'd20, 8'd200, 1'b0));
    send_request(make_job(16'd0, 16'd500, 16'd0,  8'hFF,  1'b1));

    // full batch, then a last request that finds no room but still schedules
    for (int i = 0; i < MAX_JOBS; i++)
      send_request(random_job(MIX_CROWDED, 1'b0));
    send_request(random_job(MIX_FULL, 1'b1));

    // -- random part: whole batches, a few of them overflowing --
    random_sent = 0;
    while (random_sent < RANDOM_REQUESTS) begin
      batch_mix  = job_mix_t'($urandom_range(0, 2));
      batch_size = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4)
                                              : $urandom_range(1, MAX_JOBS);
      for (int j = 0; j < batch_size; j++) begin
        item_mix = ($urandom_range(0, 5) == 0) ? MIX_FULL : batch_mix;
        send_request(random_job(item_mix, 1'(j == batch_size - 1)));
      end
      random_sent += batch_size;
    end

    start <= 1'b0;
    while (sched_sb.pending_runs.size() != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests in %0d batches (%0d dropped on a full batch)",
             sched_sb.requests, sched_sb.batches, sched_sb.dropped);
    $display("%0d scheduled jobs checked, %0d of them after an idle stretch, %0d mismatches",
             sched_sb.results_checked, sched_sb.idle_starts, sched_sb.mismatches);
    if (sched_sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
